// File: rtl/ctt_pkg.sv
// Shared types, codes and constants of the cooking timer / thermostat.
package ctt_pkg;

  // Action codes carried in the input item
  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_MODE  = 3'd1,
    ACT_START = 3'd2,
    ACT_STOP  = 3'd3,
    ACT_INC   = 3'd4,
    ACT_DEC   = 3'd5,
    ACT_CLEAR = 3'd6,
    ACT_TEMP  = 3'd7
  } ctt_action_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND     = 1'd1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] MAX_TIME_RST = 16'd36000;
  localparam logic [9:0]  BAND_RST     = 10'd10;

  // Step modes
  localparam logic [2:0] MODE_SEC   = 3'd0;
  localparam logic [2:0] MODE_10SEC = 3'd1;
  localparam logic [2:0] MODE_MIN   = 3'd2;
  localparam logic [2:0] MODE_10MIN = 3'd3;
  localparam logic [2:0] MODE_HOUR  = 3'd4;

  // Reciprocals for the h:m:s split.
  // seconds / 60 : (x * 69906) >> 22, exact for x < 2^16
  localparam logic [16:0] RCP_DIV60_16 = 17'd69906;
  localparam int unsigned SH_DIV60_16  = 22;
  // minutes / 60 : (t * 1093) >> 16, exact for t <= 1092
  localparam logic [10:0] RCP_DIV60_11 = 11'd1093;
  localparam int unsigned SH_DIV60_11  = 16;
  localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

  typedef struct packed {
    logic [2:0]  action;
    logic [13:0] temperature;
    logic [10:0] setpoint;
  } ctt_in_t;

  typedef struct packed {
    logic [4:0] hours_left;
    logic [5:0] minutes_left;
    logic [5:0] seconds_left;
    logic [2:0] step_mode_out;
    logic       cooking_on;
    logic       heater_on;
    logic       buzzer_start;
  } ctt_out_t;

  // Timer snapshot after one action, before the h:m:s split
  typedef struct packed {
    logic [15:0] secs;
    logic [2:0]  mode;
    logic        cooking;
    logic        heater;
    logic        buzz;
  } ctt_snap_t;

  function automatic logic [11:0] ctt_step_size(input logic [2:0] mode);
    logic [11:0] step;
    case (mode)
      MODE_SEC:   step = 12'd1;
      MODE_10SEC: step = 12'd10;
      MODE_MIN:   step = 12'd60;
      MODE_10MIN: step = 12'd600;
      MODE_HOUR:  step = 12'd3600;
      default:    step = 12'd0;
    endcase
    return step;
  endfunction

endpackage

// File: rtl/ctt_ctrl.sv
// Input register and timer/thermostat state update.
module ctt_ctrl import ctt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ctt_in_t     in_data,
  input  logic [15:0] max_time,
  input  logic [9:0]  band,
  output logic        snap_valid,
  input  logic        snap_ready,
  output ctt_snap_t   snap
);

  logic        s0_v_r;
  ctt_in_t     in_r;
  logic        s1_v_r;
  ctt_snap_t   snap_r;

  logic [15:0] rem_r, rem_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic        cook_r, cook_nxt;
  logic        heat_r, heat_nxt;
  logic        buzz;

  logic        rdy_s0, rdy_s1, adv;
  logic [11:0] step;
  logic [16:0] inc_sum;
  logic [14:0] temp_lo;
  logic [11:0] sp_hi;

  assign rdy_s1   = !s1_v_r || snap_ready;
  assign rdy_s0   = !s0_v_r || rdy_s1;
  assign in_stall = !rdy_s0;
  assign adv      = s0_v_r && rdy_s1;

  assign step    = ctt_step_size(mode_r);
  assign inc_sum = {1'b0, rem_r} + 17'(step);
  assign temp_lo = {1'b0, in_r.temperature} + 15'(band);
  assign sp_hi   = {1'b0, in_r.setpoint} + 12'(band);

  always_comb begin
    rem_nxt  = rem_r;
    mode_nxt = mode_r;
    cook_nxt = cook_r;
    heat_nxt = heat_r;
    buzz     = 1'b0;
    case (ctt_action_t'(in_r.action))
      ACT_TICK: begin
        if (cook_r && rem_r != 16'd0) begin
          rem_nxt = rem_r - 16'd1;
          if (rem_r == 16'd1) begin
            cook_nxt = 1'b0;
            heat_nxt = 1'b0;
            buzz     = 1'b1;
          end
        end
      end
      ACT_MODE:  mode_nxt = (mode_r < MODE_HOUR) ? mode_r + 3'd1 : MODE_SEC;
      ACT_START: if (rem_r != 16'd0) cook_nxt = 1'b1;
      ACT_STOP: begin
        cook_nxt = 1'b0;
        heat_nxt = 1'b0;
      end
      ACT_INC: begin
        // also pulls a time above a lowered limit back down
        rem_nxt = (inc_sum > {1'b0, max_time}) ? max_time : inc_sum[15:0];
      end
      ACT_DEC: rem_nxt = (rem_r > 16'(step)) ? rem_r - 16'(step) : 16'd0;
      ACT_CLEAR: begin
        cook_nxt = 1'b0;
        heat_nxt = 1'b0;
        rem_nxt  = 16'd0;
      end
      ACT_TEMP: begin
        if (cook_r) begin
          if (temp_lo < {4'd0, in_r.setpoint}) heat_nxt = 1'b1;
          else if (in_r.temperature > {2'd0, sp_hi}) heat_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      rem_r  <= 16'd0;
      mode_r <= MODE_SEC;
      cook_r <= 1'b0;
      heat_r <= 1'b0;
    end else begin
      if (rdy_s0) s0_v_r <= in_valid;
      if (rdy_s1) s1_v_r <= s0_v_r;
      if (adv) begin
        rem_r  <= rem_nxt;
        mode_r <= mode_nxt;
        cook_r <= cook_nxt;
        heat_r <= heat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy_s0) in_r <= in_data;
    if (adv) begin
      snap_r.secs    <= rem_nxt;
      snap_r.mode    <= mode_nxt;
      snap_r.cooking <= cook_nxt;
      snap_r.heater  <= heat_nxt;
      snap_r.buzz    <= buzz;
    end
  end

  assign snap_valid = s1_v_r;
  assign snap       = snap_r;

  // heater only runs during a countdown
  a_heat_needs_cook: assert property (@(posedge clk) disable iff (!rst_n)
    heat_r |-> cook_r)
    else $error("heater on while not cooking");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= MODE_HOUR)
    else $error("step mode out of range");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_r.action == ACT_CLEAR) |=> (rem_r == 16'd0 && !cook_r && !heat_r))
    else $error("clear left timer state behind");

  a_buzz_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && snap_r.buzz) |-> (snap_r.secs == 16'd0 && !snap_r.cooking))
    else $error("buzzer without countdown end");

endmodule

// File: rtl/ctt_split.sv
// Three-stage split of remaining seconds into h:m:s; the last stage is the output register.
module ctt_split import ctt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      snap_valid,
  output logic      snap_ready,
  input  ctt_snap_t snap,
  output logic      out_valid,
  input  logic      out_stall,
  output ctt_out_t  out_data
);

  // stage 2: total minutes
  logic        s2_v_r;
  ctt_snap_t   s2_snap_r;
  logic [10:0] s2_tm_r;
  // stage 3: hours and seconds
  logic        s3_v_r;
  ctt_snap_t   s3_snap_r;
  logic [10:0] s3_tm_r;
  logic [4:0]  s3_h_r;
  logic [5:0]  s3_s_r;
  // output
  logic        out_v_r;
  ctt_out_t    out_r;

  logic        rdy_out, rdy_s3, rdy_s2;
  logic [32:0] tm_prod;
  logic [21:0] h_prod;
  logic [15:0] sec_diff;
  logic [10:0] min_diff;

  assign rdy_out    = !out_v_r || !out_stall;
  assign rdy_s3     = !s3_v_r || rdy_out;
  assign rdy_s2     = !s2_v_r || rdy_s3;
  assign snap_ready = rdy_s2;

  assign tm_prod  = 33'(snap.secs) * 33'(RCP_DIV60_16);
  assign h_prod   = 22'(s2_tm_r) * 22'(RCP_DIV60_11);
  assign sec_diff = s2_snap_r.secs - 16'(s2_tm_r) * 16'(SEC_PER_MIN);
  assign min_diff = s3_tm_r - 11'(s3_h_r) * 11'(SEC_PER_MIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy_s2)  s2_v_r  <= snap_valid;
      if (rdy_s3)  s3_v_r  <= s2_v_r;
      if (rdy_out) out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && rdy_s2) begin
      s2_snap_r <= snap;
      s2_tm_r   <= tm_prod[SH_DIV60_16 +: 11];
    end
    if (s2_v_r && rdy_s3) begin
      s3_snap_r <= s2_snap_r;
      s3_tm_r   <= s2_tm_r;
      s3_h_r    <= h_prod[SH_DIV60_11 +: 5];
      s3_s_r    <= sec_diff[5:0];
    end
    if (s3_v_r && rdy_out) begin
      out_r.hours_left    <= s3_h_r;
      out_r.minutes_left  <= min_diff[5:0];
      out_r.seconds_left  <= s3_s_r;
      out_r.step_mode_out <= s3_snap_r.mode;
      out_r.cooking_on    <= s3_snap_r.cooking;
      out_r.heater_on     <= s3_snap_r.heater;
      out_r.buzzer_start  <= s3_snap_r.buzz;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_hms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.minutes_left < SEC_PER_MIN && out_r.seconds_left < SEC_PER_MIN))
    else $error("minutes or seconds out of range");

endmodule

// File: rtl/cook_timer_thermostat.sv
// Top level of the cooking timer with heater thermostat.
// Usage:
//   Input channel in_valid/in_stall/in_data carries one action per transfer
//   (tick, mode, start, stop, increment, decrement, clear, temperature sample).
//   Every transfer yields exactly one result on out_valid/out_stall/out_data:
//   remaining time as h:m:s, step mode, cooking/heater flags and buzzer pulse.
//   Throughput: one item per cycle while out_stall is low; each action
//   updates the timer state, and the h:m:s split runs in three following
//   pipeline stages.
//   When out_stall is high the pipeline fills up; in_stall rises only once
//   every stage holds an item, so bubbles are squeezed out first.
//   cfg_we/cfg_index/cfg_wdata write max_time (index 0) and band (index 1);
//   write them only while no item is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline, clears the time,
//   step mode, cooking and heater flags, and loads max_time 36000 and band 10.
module cook_timer_thermostat import ctt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ctt_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ctt_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0] max_time_r;
  logic [9:0]  band_r;
  logic        snap_valid, snap_ready;
  ctt_snap_t   snap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_time_r <= MAX_TIME_RST;
      band_r     <= BAND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_TIME: max_time_r <= cfg_wdata[15:0];
        CFG_BAND:     band_r     <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  ctt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .max_time   (max_time_r),
    .band       (band_r),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  ctt_split u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
